// ----- hdl/ctcw_pkg.sv -----
// Shared types and constants for the text console cell writer.
// No dependencies; imported by every module of the block but ctcw_ram.
`default_nettype none

package ctcw_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;
    localparam int TAB_STOP_DEF = 4;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_COLS   = 2'd1;
    localparam logic [1:0] CFG_ROWS   = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic       ENABLE_RESET = 1'b1;
    localparam logic [7:0] COLS_RESET   = 8'd64;
    localparam logic [6:0] ROWS_RESET   = 7'd48;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [7:0]  cell_char;
        logic [63:0] update_count;
    } out_item_t;

    typedef enum logic [3:0] {
        CMD_PRINT,
        CMD_NEWLINE,
        CMD_CR,
        CMD_TAB,
        CMD_BS,
        CMD_COUNT,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] char_code;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_TAB,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_BLANK,
        ST_CLEAR,
        ST_RESULT
    } back_state_t;

endpackage

`default_nettype wire

// ----- hdl/ctcw_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none

module ctcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/ctcw_front.sv -----
// Front end: accepts input transactions, classifies them into commands
// and holds them in a two-entry queue. Depends on ctcw_pkg.
`default_nettype none

module ctcw_front import ctcw_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     enable,
    input  wire logic     busy,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  wire logic     cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       cls;
    logic       push;

    always_comb begin
        cls.char_code = s_data.char_code;
        cls.read_row  = s_data.read_row;
        cls.read_col  = s_data.read_col;
        cls.kind      = CMD_NOP;
        case (s_data.operation)
            OP_PUT: begin
                if (enable) begin
                    case (s_data.char_code)
                        CH_LF:   cls.kind = CMD_NEWLINE;
                        CH_CR:   cls.kind = CMD_CR;
                        CH_TAB:  cls.kind = CMD_TAB;
                        CH_BS:   cls.kind = CMD_BS;
                        default: cls.kind = (s_data.char_code < CH_SPACE) ? CMD_COUNT
                                                                            : CMD_PRINT;
                    endcase
                end
            end
            OP_CLEAR: cls.kind = enable ? CMD_CLEAR : CMD_NOP;
            OP_READ:  cls.kind = CMD_READ;
            default:  cls.kind = CMD_NOP;
        endcase
    end

    assign s_ready   = (fill_reg != 2'd2) && !busy;
    assign push      = s_valid && s_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ctcw_back.sv -----
// Back end: executes queued commands against the character grid RAM,
// tracks cursor and update counter, and drives the result register.
// Depends on ctcw_pkg and ctcw_ram.
`default_nettype none

module ctcw_back import ctcw_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] cols_in_use,
    input  wire logic [6:0] rows_in_use,
    output logic            busy,
    input  wire logic       cmd_valid,
    input  wire cmd_t       cmd,
    output logic            cmd_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int PW = $clog2(TAB_STOP);
    localparam logic [AW-1:0] STRIDE = AW'(1) << CW;

    back_state_t     state_reg, state_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [PW-1:0]   phase_reg, phase_next;
    logic [63:0]     count_reg, count_next;
    logic [AW-1:0]   sweep_reg, sweep_next;
    logic            copy_pend_reg, copy_pend_next;
    logic [AW-1:0]   copy_addr_reg, copy_addr_next;
    logic            read_ok_reg, read_ok_next;
    logic [7:0]      cell_reg, cell_next;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_data_reg, m_data_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [7:0]      wdata, rdata;

    logic [8:0]      eff_cols;
    logic [7:0]      eff_rows;
    logic [9:0]      col_inc;
    logic [7:0]      row_inc;
    logic            wrap, need_scroll;
    logic [RW-1:0]   last_row;
    logic [PW-1:0]   phase_inc;
    logic [AW-1:0]   scroll_start, scroll_end;
    back_state_t     scroll_state;
    logic            out_free;
    logic [15:0]     rd_row_w, rd_col_w;
    logic            sweep_last, row_last;

    ctcw_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_grid (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        if (cols_in_use == 8'd0) begin
            eff_cols = 9'd1;
        end else if (9'(cols_in_use) > 9'(MAX_COLS)) begin
            eff_cols = 9'(MAX_COLS);
        end else begin
            eff_cols = 9'(cols_in_use);
        end
        if (rows_in_use == 7'd0) begin
            eff_rows = 8'd1;
        end else if (8'(rows_in_use) > 8'(MAX_ROWS)) begin
            eff_rows = 8'(MAX_ROWS);
        end else begin
            eff_rows = 8'(rows_in_use);
        end
    end

    assign col_inc      = 10'(col_reg) + 10'd1;
    assign wrap         = col_inc >= 10'(eff_cols);
    assign row_inc      = 8'(row_reg) + 8'd1;
    assign need_scroll  = row_inc >= eff_rows;
    assign last_row     = RW'(eff_rows - 8'd1);
    assign phase_inc    = (phase_reg == PW'(TAB_STOP - 1)) ? '0 : phase_reg + PW'(1);
    assign scroll_state = (eff_rows == 8'd1) ? ST_BLANK : ST_SCROLL;
    assign scroll_start = (eff_rows == 8'd1) ? {last_row, CW'(0)} : STRIDE;
    assign scroll_end   = {last_row, {CW{1'b1}}};
    assign out_free     = !m_valid_reg || m_ready;
    assign rd_row_w     = 16'(cmd.read_row);
    assign rd_col_w     = 16'(cmd.read_col);
    assign sweep_last   = (sweep_reg == {AW{1'b1}});
    assign row_last     = (sweep_reg[CW-1:0] == {CW{1'b1}});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_PRINT:   state_next = (wrap && need_scroll) ? scroll_state
                                                                        : ST_RESULT;
                        CMD_NEWLINE: state_next = need_scroll ? scroll_state : ST_RESULT;
                        CMD_TAB:     state_next = ST_TAB;
                        CMD_READ:    state_next = ST_READ_WAIT;
                        CMD_CLEAR:   state_next = ST_CLEAR;
                        default:     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_TAB: begin
                if (wrap) begin
                    state_next = need_scroll ? scroll_state : ST_RESULT;
                end else if (phase_inc == '0) begin
                    state_next = ST_RESULT;
                end
            end
            ST_READ_WAIT:  state_next = ST_RESULT;
            ST_SCROLL: begin
                if (sweep_reg == scroll_end) state_next = ST_SCROLL_END;
            end
            ST_SCROLL_END: state_next = ST_BLANK;
            ST_BLANK: begin
                if (row_last) state_next = ST_RESULT;
            end
            ST_CLEAR: begin
                if (sweep_last) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        row_next       = row_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        sweep_next     = sweep_reg;
        copy_pend_next = 1'b0;
        copy_addr_next = copy_addr_reg;
        read_ok_next   = read_ok_reg;
        cell_next      = cell_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        we             = 1'b0;
        waddr          = {row_reg, col_reg};
        wdata          = CH_SPACE;
        raddr          = sweep_reg;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            ST_INIT, ST_CLEAR, ST_BLANK: begin
                we         = 1'b1;
                waddr      = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
            end
            ST_IDLE: begin
                raddr = {rd_row_w[RW-1:0], rd_col_w[CW-1:0]};
                if (cmd_valid) begin
                    cmd_pop   = 1'b1;
                    cell_next = 8'd0;
                    case (cmd.kind)
                        CMD_PRINT, CMD_NEWLINE: begin
                            count_next = count_reg + 64'd1;
                            if (cmd.kind == CMD_PRINT) begin
                                we    = 1'b1;
                                wdata = cmd.char_code;
                            end
                            if (cmd.kind == CMD_NEWLINE || wrap) begin
                                col_next   = '0;
                                phase_next = '0;
                                if (need_scroll) begin
                                    row_next   = last_row;
                                    sweep_next = scroll_start;
                                end else begin
                                    row_next = RW'(row_inc);
                                end
                            end else begin
                                col_next   = CW'(col_inc);
                                phase_next = phase_inc;
                            end
                        end
                        CMD_CR: begin
                            count_next = count_reg + 64'd1;
                            col_next   = '0;
                            phase_next = '0;
                        end
                        CMD_TAB, CMD_COUNT: count_next = count_reg + 64'd1;
                        CMD_BS: begin
                            count_next = count_reg + 64'd1;
                            if (col_reg != '0) begin
                                col_next   = col_reg - CW'(1);
                                phase_next = (phase_reg == '0) ? PW'(TAB_STOP - 1)
                                                               : phase_reg - PW'(1);
                                we         = 1'b1;
                                waddr      = {row_reg, col_reg - CW'(1)};
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = count_reg + 64'd1;
                            row_next   = '0;
                            col_next   = '0;
                            phase_next = '0;
                            sweep_next = '0;
                        end
                        CMD_READ: begin
                            read_ok_next = (32'(cmd.read_row) < MAX_ROWS)
                                        && (32'(cmd.read_col) < MAX_COLS);
                        end
                        default: ;
                    endcase
                end
            end
            ST_TAB: begin
                we         = 1'b1;
                count_next = count_reg + 64'd1;
                if (wrap) begin
                    col_next   = '0;
                    phase_next = '0;
                    if (need_scroll) begin
                        row_next   = last_row;
                        sweep_next = scroll_start;
                    end else begin
                        row_next = RW'(row_inc);
                    end
                end else begin
                    col_next   = CW'(col_inc);
                    phase_next = phase_inc;
                end
            end
            ST_READ_WAIT: cell_next = read_ok_reg ? rdata : CH_SPACE;
            ST_SCROLL: begin
                // read row r, write it one row up in the following cycle
                raddr          = sweep_reg;
                copy_pend_next = 1'b1;
                copy_addr_next = sweep_reg - STRIDE;
                sweep_next     = sweep_reg + AW'(1);
                we             = copy_pend_reg;
                waddr          = copy_addr_reg;
                wdata          = rdata;
            end
            ST_SCROLL_END: begin
                we         = copy_pend_reg;
                waddr      = copy_addr_reg;
                wdata      = rdata;
                sweep_next = {last_row, CW'(0)};
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.cursor_row   = 6'(row_reg);
                    m_data_next.cursor_col   = 7'(col_reg);
                    m_data_next.cell_char    = cell_reg;
                    m_data_next.update_count = count_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            count_reg     <= '0;
            sweep_reg     <= '0;
            copy_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            sweep_reg     <= sweep_next;
            copy_pend_reg <= copy_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= copy_addr_next;
        read_ok_reg   <= read_ok_next;
        cell_reg      <= cell_next;
        m_data_reg    <= m_data_next;
    end

    assign busy    = (state_reg == ST_INIT);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- hdl/text_console_cell_writer.sv -----
// Top level of the text console cell writer: configuration registers,
// front end with command queue, and back end with the grid RAM.
// Depends on ctcw_pkg, ctcw_front, ctcw_back.
//
//  channel   ports                       handshake
//  input     s_valid s_ready s_data      valid/ready, in_item_t
//  result    m_valid m_ready m_data      valid/ready, out_item_t
//  config    cfg_we cfg_index cfg_data   write on cfg_we, no wait
//
// put, return, backspace and ignored codes go from idle to the result state
// in the back end (a put that wraps past the last row scrolls first); reads
// pass a read-wait state, and a tab stays in its tab state while it writes its spaces.
// a scroll walks the grid RAM port one cell a cycle; a clear writes all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (8192 at the defaults).
// after reset the same clearing pass runs and s_ready stays low meanwhile.
// the two-entry queue and the result register keep the input taking
// transactions while a result waits.
`default_nettype none

module text_console_cell_writer import ctcw_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic       enable_reg;
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;
    logic       busy;
    logic       cmd_valid;
    logic       cmd_pop;
    cmd_t       cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= ENABLE_RESET;
            cols_reg   <= COLS_RESET;
            rows_reg   <= ROWS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_COLS:   cols_reg   <= cfg_data;
                CFG_ROWS:   rows_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    ctcw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable_reg),
        .busy      (busy),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ctcw_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cols_in_use (cols_reg),
        .rows_in_use (rows_reg),
        .busy        (busy),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ----- hdl/ctcw_checker.sv -----
// Port-level checks for the text console cell writer, bound to the top.
// Depends on ctcw_pkg and text_console_cell_writer.
`default_nettype none

module ctcw_checker import ctcw_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // a waiting result must hold still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // grid is being cleared after reset, no transaction may enter
    a_init_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken during clearing pass");

    // grid only ever holds bytes at or above the space code
    a_cell_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cell_char == 8'd0) || (m_data.cell_char >= CH_SPACE))
        else $error("cell read returned a control byte");

endmodule

bind text_console_cell_writer ctcw_checker u_ctcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for text_console_cell_writer: random and directed put, clear and read traffic
// checked against an in-bench model of the grid, the cursor and the update counter.
// Depends on ctcw_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
    import ctcw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NROWS = MAX_ROWS_DEF;
    localparam int NCOLS = MAX_COLS_DEF;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    always #6 aclk = ~aclk;

    text_console_cell_writer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // console model
    logic [7:0]  grid_model [NROWS][NCOLS];
    int          cur_row;
    int          cur_col;
    logic [63:0] upd_count;
    logic        cfg_enable;
    logic [7:0]  cfg_cols;
    logic [6:0]  cfg_rows;

    out_item_t expected_results[$];
    int        errors = 0;
    int        hold_left = 0;
    bit        quiet = 1'b0;

    function automatic int cols_used();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > NCOLS) return NCOLS;
        return cfg_cols;
    endfunction

    function automatic int rows_used();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > NROWS) return NROWS;
        return cfg_rows;
    endfunction

    function automatic void blank_grid();
        for (int r = 0; r < NROWS; r++)
            for (int c = 0; c < NCOLS; c++)
                grid_model[r][c] = CH_SPACE;
    endfunction

    function automatic void line_feed();
        int n;
        n = rows_used();
        cur_col = 0;
        cur_row++;
        if (cur_row >= n) begin
            for (int r = 1; r < n; r++)
                for (int c = 0; c < NCOLS; c++)
                    grid_model[r-1][c] = grid_model[r][c];
            for (int c = 0; c < NCOLS; c++)
                grid_model[n-1][c] = CH_SPACE;
            cur_row = n - 1;
        end
    endfunction

    function automatic void store_char(logic [7:0] ch);
        if (cur_row < NROWS && cur_col < NCOLS)
            grid_model[cur_row][cur_col] = ch;
        cur_col++;
        if (cur_col >= cols_used())
            line_feed();
    endfunction

    function automatic void put_char(logic [7:0] ch);
        upd_count++;
        case (ch)
            CH_LF: line_feed();
            CH_CR: cur_col = 0;
            CH_TAB: begin
                do begin
                    upd_count++;
                    store_char(CH_SPACE);
                end while (cur_col % TAB_STOP_DEF != 0);
            end
            CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                    if (cur_row < NROWS && cur_col < NCOLS)
                        grid_model[cur_row][cur_col] = CH_SPACE;
                end
            end
            default: begin
                if (ch >= CH_SPACE)
                    store_char(ch);
            end
        endcase
    endfunction

    function automatic out_item_t console_result(in_item_t it);
        out_item_t r;
        r.cell_char = 8'h00;
        case (it.operation)
            OP_PUT: if (cfg_enable) put_char(it.char_code);
            OP_CLEAR: begin
                if (cfg_enable) begin
                    blank_grid();
                    cur_row = 0;
                    cur_col = 0;
                    upd_count++;
                end
            end
            OP_READ: r.cell_char = grid_model[it.read_row][it.read_col];
            default: ;
        endcase
        r.cursor_row   = cur_row[5:0];
        r.cursor_col   = cur_col[6:0];
        r.update_count = upd_count;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_data.update_count, 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", m_data.cursor_row, want.cursor_row);
                if (m_data.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", m_data.cursor_col, want.cursor_col);
                if (m_data.cell_char !== want.cell_char)
                    report_mismatch("cell_char", m_data.cell_char, want.cell_char);
                if (m_data.update_count !== want.update_count)
                    report_mismatch("update_count", m_data.update_count, want.update_count);
            end
        end
    end

    // receiver: random stalls, or a counted hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 20);
        end
    end

    task automatic send_item(in_item_t it);
        if (!quiet && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(console_result(it));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_ENABLE: cfg_enable = val[0];
            CFG_COLS:   cfg_cols = val;
            CFG_ROWS:   cfg_rows = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_console(logic en, logic [7:0] cols, logic [7:0] rows);
        write_reg(CFG_ENABLE, {7'd0, en});
        write_reg(CFG_COLS, cols);
        write_reg(CFG_ROWS, rows);
    endtask

    function automatic in_item_t make_item(logic [1:0] op, logic [7:0] ch,
                                           logic [5:0] rr, logic [6:0] rc);
        in_item_t it;
        it.operation = op;
        it.char_code = ch;
        it.read_row  = rr;
        it.read_col  = rc;
        return it;
    endfunction

    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return 8'($urandom_range(8'h20, 8'hFF));
        if (pick < 63) return CH_LF;
        if (pick < 68) return CH_CR;
        if (pick < 75) return CH_TAB;
        if (pick < 83) return CH_BS;
        return 8'($urandom);
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        it = in_item_t'($urandom);
        pick = $urandom_range(999);
        if (pick < 790) begin
            it.operation = OP_PUT;
            it.char_code = random_char();
        end else if (pick < 985) begin
            it.operation = OP_READ;
            // half the time, aim inside the area in use
            if ($urandom_range(1)) begin
                it.read_row = 6'($urandom_range(0, rows_used() - 1));
                it.read_col = 7'($urandom_range(0, cols_used() - 1));
            end
        end else if (pick < 995) begin
            it.operation = OP_UNUSED;
        end else begin
            it.operation = OP_CLEAR;
        end
        return it;
    endfunction

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++)
            send_item(random_item());
        drain();
    endtask

    task automatic test_directed();
        send_item(make_item(OP_READ, 8'h00, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, 8'h20, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, 8'hFF, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, 8'h7F, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, 8'h41, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, CH_BS, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, CH_TAB, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, CH_TAB, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, CH_CR, 6'd0, 7'd0));
        // backspace at column zero only counts
        send_item(make_item(OP_PUT, CH_BS, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, 8'h00, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, 8'h1F, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, CH_LF, 6'd0, 7'd0));
        send_item(make_item(OP_READ, 8'hFF, 6'd0, 7'd1));
        send_item(make_item(OP_READ, 8'h00, 6'd63, 7'd127));
        send_item(make_item(OP_UNUSED, 8'hFF, 6'd63, 7'd127));
        send_item(make_item(OP_CLEAR, 8'h00, 6'd0, 7'd0));
        send_item(make_item(OP_READ, 8'h00, 6'd0, 7'd1));
        drain();
        // one column, one row: every byte wraps and scrolls
        set_console(1'b1, 8'd1, 8'd1);
        send_item(make_item(OP_PUT, 8'h5A, 6'd0, 7'd0));
        send_item(make_item(OP_PUT, CH_TAB, 6'd0, 7'd0));
        send_item(make_item(OP_READ, 8'h00, 6'd0, 7'd0));
        drain();
        // disabled: puts and clears leave everything alone
        write_reg(CFG_ENABLE, 8'd0);
        send_item(make_item(OP_PUT, 8'h42, 6'd0, 7'd0));
        send_item(make_item(OP_CLEAR, 8'h00, 6'd0, 7'd0));
        send_item(make_item(OP_READ, 8'h00, 6'd0, 7'd0));
        drain();
    endtask

    task automatic test_random();
        set_console(1'b1, 8'd16, 8'd4);
        random_burst(150);
        set_console(1'b1, 8'd128, 8'd8);
        random_burst(110);
        // shrink with the cursor possibly outside the new area
        set_console(1'b1, 8'd7, 8'd3);
        random_burst(100);
        quiet = 1'b1;
        set_console(1'b1, 8'd0, 8'd0);
        random_burst(40);
        quiet = 1'b0;
        set_console(1'b1, 8'd1, 8'd1);
        random_burst(40);
        set_console(1'b0, 8'd20, 8'd5);
        random_burst(40);
        set_console(1'b1, 8'd128, 8'd64);
        random_burst(50);
        // counts above the grid saturate
        set_console(1'b1, 8'd255, 8'd255);
        random_burst(40);
        set_console(1'b1, 8'd10, 8'd6);
        random_burst(60);
    endtask

    task automatic test_backpressure();
        hold_left = 300;
        for (int i = 0; i < 16; i++)
            send_item(make_item(OP_PUT, 8'($urandom_range(8'h20, 8'hFF)), 6'd0, 7'd0));
        drain();
    endtask

    initial begin
        #(64'd500_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= 8'd0;
        blank_grid();
        cur_row    = 0;
        cur_col    = 0;
        upd_count  = 64'd0;
        cfg_enable = ENABLE_RESET;
        cfg_cols   = COLS_RESET;
        cfg_rows   = ROWS_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ctcw_pkg.sv
hdl/ctcw_ram.sv
hdl/ctcw_front.sv
hdl/ctcw_back.sv
hdl/text_console_cell_writer.sv
hdl/ctcw_checker.sv
sim/tb_top.sv
